// ===== hw/rtl/rs_enc_pkg.sv =====
package rs_enc_pkg;

   localparam int NUM_ROOTS    = 16;
   localparam int MAX_DATA_LEN = 239;
   localparam int SYM_W        = 8;
   localparam int IDX_W        = 4;
   localparam int CNT_W        = $clog2(NUM_ROOTS + 1);
   localparam int BYTE_CNT_W   = 8;

   localparam logic [SYM_W:0] GF_POLY = 9'h187;

   typedef logic [SYM_W-1:0] sym_type;
   typedef sym_type [NUM_ROOTS:0] coef_arr_type;

   // per-cycle commands shared by every cell of the chain
   typedef struct packed {
      logic step;   // input byte transfer
      logic last;   // that byte closes the codeword
      logic shift;  // result transfer, unload chain moves one place
   } cell_ctrl_type;

   function automatic sym_type gf_mul(sym_type a, sym_type b);
      logic [SYM_W:0] x;
      sym_type acc;
      acc = '0;
      x   = {1'b0, a};
      for (int i = 0; i < SYM_W; i++) begin
         if (b[i]) acc ^= x[SYM_W-1:0];
         x = {x[SYM_W-1:0], 1'b0};
         if (x[SYM_W]) x ^= GF_POLY;
      end
      return acc;
   endfunction

   // generator = prod (x + alpha^r), r = 0 .. NUM_ROOTS-1; entry i multiplies x^i
   function automatic coef_arr_type gen_build();
      coef_arr_type g;
      sym_type root;
      g    = '0;
      g[0] = sym_type'(1);
      root = sym_type'(1);
      for (int j = 0; j < NUM_ROOTS; j++) begin
         g[j+1] = sym_type'(1);
         for (int k = j; k > 0; k--) begin
            g[k] = g[k-1] ^ gf_mul(g[k], root);
         end
         g[0] = gf_mul(g[0], root);
         root = gf_mul(root, sym_type'(2));
      end
      return g;
   endfunction

   localparam coef_arr_type GEN_COEF = gen_build();

endpackage

// ===== hw/rtl/rs_255_239_shortened_encoder_top.sv =====
// Parity symbol 0 is offered the cycle after the last data byte transfer,
// the rest follow one per cycle as the sink takes them (16 parity symbols per codeword).
// Throughput: one data byte per cycle; a last byte waits only while the previous
// codeword's parity is still unloading (the final parity transfer frees it).
// Reset: synchronous, active high; clears the LFSR, byte counter and unload state.
module rs_255_239_shortened_encoder_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] parity_byte, [11:8] parity_index, [15:12] zero
   output logic        rsp_tlast,   // last_parity
   output logic        rsp_tuser    // too_long
);
   import rs_enc_pkg::*;

   cell_ctrl_type                ctrl;
   sym_type [NUM_ROOTS-1:0]      lfsr_q;
   sym_type [NUM_ROOTS-1:0]      unld_q;
   sym_type [NUM_ROOTS:0]        lfsr_link;
   sym_type [NUM_ROOTS:0]        unld_link;
   sym_type                      feedback;
   logic [IDX_W-1:0]             rsp_index;

   rs_enc_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tlast    (req_tlast),
      .req_tready   (req_tready),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_index    (rsp_index),
      .rsp_last     (rsp_tlast),
      .rsp_too_long (rsp_tuser),
      .ctrl         (ctrl)
   );

   assign feedback = req_tdata ^ lfsr_q[0];

   assign lfsr_link[NUM_ROOTS] = '0;
   assign unld_link[NUM_ROOTS] = '0;

   for (genvar j = 0; j < NUM_ROOTS; j++) begin : g_cell
      assign lfsr_link[j] = lfsr_q[j];
      assign unld_link[j] = unld_q[j];

      rs_enc_cell u_cell (
         .clock          (clock),
         .ctrl           (ctrl),
         .coef           (GEN_COEF[NUM_ROOTS-1-j]),
         .feedback       (feedback),
         .lfsr_next_cell (lfsr_link[j+1]),
         .unld_next_cell (unld_link[j+1]),
         .reset          (reset),
         .lfsr_out       (lfsr_q[j]),
         .unld_out       (unld_q[j])
      );
   end

   assign rsp_tdata = {4'b0000, rsp_index, unld_link[0]};

endmodule

// ===== hw/rtl/rs_enc_cell.sv =====
module rs_enc_cell (
   input  logic                   clock,
   input  rs_enc_pkg::cell_ctrl_type ctrl,
   input  rs_enc_pkg::sym_type    coef,
   input  rs_enc_pkg::sym_type    feedback,
   input  rs_enc_pkg::sym_type    lfsr_next_cell,
   input  rs_enc_pkg::sym_type    unld_next_cell,
   input  logic                   reset,
   output rs_enc_pkg::sym_type    lfsr_out,
   output rs_enc_pkg::sym_type    unld_out
);
   import rs_enc_pkg::*;

   sym_type lfsr_ff, lfsr_in;
   sym_type unld_ff, unld_in;
   sym_type upd;

   assign upd = lfsr_next_cell ^ gf_mul(feedback, coef);

   always_comb begin
      lfsr_in = lfsr_ff;
      if (ctrl.step) begin
         lfsr_in = ctrl.last ? '0 : upd;
      end
   end

   // snapshot of the finished parity wins over a shift in the same cycle
   always_comb begin
      unld_in = unld_ff;
      if (ctrl.step && ctrl.last) begin
         unld_in = upd;
      end else if (ctrl.shift) begin
         unld_in = unld_next_cell;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lfsr_ff <= '0;
      end else begin
         lfsr_ff <= lfsr_in;
      end
   end

   always_ff @(posedge clock) begin
      unld_ff <= unld_in;
   end

   assign lfsr_out = lfsr_ff;
   assign unld_out = unld_ff;

endmodule

// ===== hw/rtl/rs_enc_ctrl.sv =====
module rs_enc_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   input  logic                      req_tlast,
   output logic                      req_tready,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [rs_enc_pkg::IDX_W-1:0] rsp_index,
   output logic                      rsp_last,
   output logic                      rsp_too_long,
   output rs_enc_pkg::cell_ctrl_type ctrl
);
   import rs_enc_pkg::*;

   logic [BYTE_CNT_W-1:0] byte_cnt_ff, byte_cnt_in;
   logic                  ovf_ff, ovf_in;
   logic [CNT_W-1:0]      unld_cnt_ff, unld_cnt_in;
   logic                  too_long_ff, too_long_in;
   logic                  in_xfer, out_xfer, unld_free, ovf_now;

   assign out_xfer  = rsp_tvalid && rsp_tready;
   assign unld_free = (unld_cnt_ff == '0) || ((unld_cnt_ff == CNT_W'(1)) && out_xfer);
   assign req_tready = !req_tlast || unld_free;
   assign in_xfer   = req_tvalid && req_tready;

   assign ovf_now = ovf_ff || (byte_cnt_ff >= BYTE_CNT_W'(MAX_DATA_LEN));

   always_comb begin
      byte_cnt_in = byte_cnt_ff;
      ovf_in      = ovf_ff;
      if (in_xfer) begin
         if (req_tlast) begin
            byte_cnt_in = '0;
            ovf_in      = 1'b0;
         end else if (byte_cnt_ff >= BYTE_CNT_W'(MAX_DATA_LEN)) begin
            ovf_in = 1'b1;
         end else begin
            byte_cnt_in = byte_cnt_ff + BYTE_CNT_W'(1);
         end
      end
   end

   always_comb begin
      unld_cnt_in = unld_cnt_ff;
      too_long_in = too_long_ff;
      if (in_xfer && req_tlast) begin
         unld_cnt_in = CNT_W'(NUM_ROOTS);
         too_long_in = ovf_now;
      end else if (out_xfer) begin
         unld_cnt_in = unld_cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_cnt_ff <= '0;
         ovf_ff      <= 1'b0;
         unld_cnt_ff <= '0;
         too_long_ff <= 1'b0;
      end else begin
         byte_cnt_ff <= byte_cnt_in;
         ovf_ff      <= ovf_in;
         unld_cnt_ff <= unld_cnt_in;
         too_long_ff <= too_long_in;
      end
   end

   assign ctrl.step  = in_xfer;
   assign ctrl.last  = req_tlast;
   assign ctrl.shift = out_xfer;

   assign rsp_tvalid   = (unld_cnt_ff != '0);
   assign rsp_index    = IDX_W'(CNT_W'(NUM_ROOTS) - unld_cnt_ff);
   assign rsp_last     = (unld_cnt_ff == CNT_W'(1));
   assign rsp_too_long = too_long_ff;

endmodule

// ===== verif/rs_255_239_shortened_encoder_checker.sv =====
`timescale 1ns / 1ps

module rs_255_239_shortened_encoder_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // last_byte
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,   // [7:0] parity_byte, [11:8] parity_index, [15:12] zero
   input  logic        rsp_tlast,   // last_parity
   input  logic        rsp_tuser,   // too_long
   output int          mismatch_count,
   output int          parity_pending
);
   import rs_enc_pkg::*;

   localparam logic [8:0] FIELD_POLY = 9'h187;

   typedef struct packed {
      sym_type          symbol;
      logic [IDX_W-1:0] index;
      logic             final_sym;
      logic             overflow;
   } parity_result_type;

   sym_type           gen_poly [NUM_ROOTS+1];
   sym_type           lfsr [NUM_ROOTS];
   int unsigned       taken_bytes;
   logic              overflowed;
   int                errors;
   parity_result_type parity_queue [$];

   function automatic sym_type gf_times(sym_type a, sym_type b);
      sym_type prod;
      prod = '0;
      // walk b from its top bit, doubling the partial product each step
      for (int i = SYM_W-1; i >= 0; i--) begin
         if (prod[SYM_W-1]) prod = (prod << 1) ^ FIELD_POLY[SYM_W-1:0];
         else prod = prod << 1;
         if (b[i]) prod ^= a;
      end
      return prod;
   endfunction

   // generator = prod (x + alpha^r), gen_poly[i] multiplies x^i
   initial begin
      sym_type root;
      root = 8'h01;
      foreach (gen_poly[i]) gen_poly[i] = '0;
      gen_poly[0] = 8'h01;
      for (int j = 0; j < NUM_ROOTS; j++) begin
         for (int k = j + 1; k > 0; k--) begin
            gen_poly[k] = gen_poly[k-1] ^ gf_times(gen_poly[k], root);
         end
         gen_poly[0] = gf_times(gen_poly[0], root);
         root = gf_times(root, 8'h02);
      end
   end

   task automatic clear_codeword();
      foreach (lfsr[j]) lfsr[j] = '0;
      taken_bytes = 0;
      overflowed = 1'b0;
   endtask

   task automatic absorb_byte(sym_type data, logic closes);
      sym_type           fb;
      parity_result_type r;
      // count saturates at the max length, longer runs flag overflow
      if (taken_bytes >= MAX_DATA_LEN) overflowed = 1'b1;
      else taken_bytes++;
      fb = data ^ lfsr[0];
      for (int j = 0; j < NUM_ROOTS-1; j++) begin
         lfsr[j] = lfsr[j+1] ^ gf_times(fb, gen_poly[NUM_ROOTS-1-j]);
      end
      lfsr[NUM_ROOTS-1] = gf_times(fb, gen_poly[0]);
      if (closes) begin
         for (int j = 0; j < NUM_ROOTS; j++) begin
            r.symbol    = lfsr[j];
            r.index     = IDX_W'(j);
            r.final_sym = (j == NUM_ROOTS-1);
            r.overflow  = overflowed;
            parity_queue.push_back(r);
         end
         clear_codeword();
      end
   endtask

   task automatic check_parity();
      parity_result_type want;
      if (parity_queue.size() == 0) begin
         errors++;
         if (errors <= 10)
            $display("unexpected parity transfer: tdata %04h last %0b user %0b",
                     rsp_tdata, rsp_tlast, rsp_tuser);
      end else begin
         want = parity_queue.pop_front();
         if (rsp_tdata[7:0] !== want.symbol || rsp_tdata[11:8] !== want.index ||
             rsp_tdata[15:12] !== 4'h0 || rsp_tlast !== want.final_sym ||
             rsp_tuser !== want.overflow) begin
            errors++;
            if (errors <= 10)
               $display("parity mismatch: expected sym %02h idx %0d last %0b long %0b,",
                        want.symbol, want.index, want.final_sym, want.overflow,
                        " got tdata %04h last %0b user %0b",
                        rsp_tdata, rsp_tlast, rsp_tuser);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_codeword();
         parity_queue.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) check_parity();
         if (req_tvalid && req_tready) absorb_byte(req_tdata, req_tlast);
      end
      mismatch_count <= errors;
      parity_pending <= parity_queue.size();
   end

endmodule

// ===== verif/rs_255_239_shortened_encoder_top_test.sv =====
`timescale 1ns / 1ps

module rs_255_239_shortened_encoder_top_test;
   import rs_enc_pkg::*;

   localparam int WATCHDOG_CYCLES = 300000;
   localparam int SETTLE_CYCLES   = 40;
   localparam int RANDOM_ITEMS    = 80;
   localparam int LONG_HOLD       = 400;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] data_byte
   logic        req_tlast;   // last_byte
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;   // [7:0] parity_byte, [11:8] parity_index, [15:12] zero
   logic        rsp_tlast;   // last_parity
   logic        rsp_tuser;   // too_long
   int          mismatch_count;
   int          parity_pending;
   logic        quiet;           // no idling on either side
   logic        long_stall_req;

   rs_255_239_shortened_encoder_top dut (.*);

   rs_255_239_shortened_encoder_checker parity_check (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (WATCHDOG_CYCLES) @(posedge clock);
      $display("rs_255_239_shortened_encoder_top test failed");
      $finish;
   end

   // sink: random back-pressure, plus one long hold-off on request
   initial begin
      bit stall_done;
      stall_done = 1'b0;
      rsp_tready = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (long_stall_req && !stall_done) begin
            stall_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (!quiet && $urandom_range(3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(12, 1)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(16, 1)) @(posedge clock);
         end
      end
   end

   task automatic send_byte(sym_type data, logic closes);
      if (!quiet && $urandom_range(4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(12, 1)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tlast  <= closes;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_codeword(int unsigned len);
      for (int unsigned i = 1; i <= len; i++) send_byte(sym_type'($urandom), i == len);
   endtask

   initial begin
      int unsigned items_sent;
      int unsigned len;
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tlast      = 1'b0;
      quiet          = 1'b0;
      long_stall_req = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // single-byte codewords at the extremes, then a three-byte word of all ones
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b1);
      send_byte(8'h01, 1'b1);
      send_byte(8'h80, 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b1);
      // leading zeros, as a shortened word would carry; then a walking-one word and a two-byte word
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h55, 1'b1);
      for (int b = 0; b < 8; b++) send_byte(sym_type'(1 << b), b == 7);
      send_byte(8'hAA, 1'b0);
      send_byte(8'h55, 1'b1);

      // hold the sink off so a second last byte backs up at the input
      long_stall_req <= 1'b1;
      send_codeword(4);
      send_codeword(3);
      send_codeword(5);

      // one word past the max length: count saturates and too_long is flagged
      send_codeword(MAX_DATA_LEN + 1);

      // random part: mostly short words
      items_sent = 0;
      while (items_sent < RANDOM_ITEMS) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(20, 1) : $urandom_range(6, 1);
         send_codeword(len);
         items_sent += len;
      end

      // closing stretch without idling
      quiet <= 1'b1;
      for (int n = 0; n < 4; n++) send_codeword($urandom_range(8, 1));
      req_tvalid <= 1'b0;

      @(posedge clock);
      while (parity_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && parity_pending == 0) begin
         $display("rs_255_239_shortened_encoder_top test passed");
      end else begin
         $display("rs_255_239_shortened_encoder_top test failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/rs_enc_pkg.sv
hw/rtl/rs_enc_cell.sv
hw/rtl/rs_enc_ctrl.sv
hw/rtl/rs_255_239_shortened_encoder_top.sv
verif/rs_255_239_shortened_encoder_checker.sv
verif/rs_255_239_shortened_encoder_top_test.sv
